// ===== rtl/core/fsfs_pkg.sv =====
// ----------------------------------------------------------------------------
// fsfs_pkg
// shared types and constants of the function start floor search block
// ----------------------------------------------------------------------------
package fsfs_pkg;

    localparam int ADDR_W    = 64;
    localparam int OFFSET_W  = 32;
    localparam int INDEX_W   = 12;
    localparam int COUNT_W   = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MODULE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODULE_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TABLE_BASE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0]  module_low;
        logic [ADDR_W-1:0]  module_high;
        logic [ADDR_W-1:0]  table_base;
        logic [COUNT_W-1:0] entry_count;
    } t_cfg;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] start_addr;
    } t_result;

endpackage

// ===== rtl/core/fsfs_cfg.sv =====
// ----------------------------------------------------------------------------
// fsfs_cfg
// configuration register file: module range, table base and entry count
// ----------------------------------------------------------------------------
module fsfs_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fsfs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fsfs_pkg::ADDR_W-1:0]      i_cfg_data,
    output fsfs_pkg::t_cfg                   o_cfg
);

    fsfs_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                fsfs_pkg::REG_MODULE_LOW:  r_cfg.module_low  <= i_cfg_data;
                fsfs_pkg::REG_MODULE_HIGH: r_cfg.module_high <= i_cfg_data;
                fsfs_pkg::REG_TABLE_BASE:  r_cfg.table_base  <= i_cfg_data;
                fsfs_pkg::REG_ENTRY_COUNT: begin
                    r_cfg.entry_count <= i_cfg_data[fsfs_pkg::COUNT_W-1:0];
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/core/fsfs_mem.sv =====
// ----------------------------------------------------------------------------
// fsfs_mem
// offset table: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module fsfs_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                              i_clk,
    input  logic                              i_wr_en,
    input  logic [AW-1:0]                     i_wr_addr,
    input  logic [fsfs_pkg::OFFSET_W-1:0]     i_wr_data,
    input  logic                              i_rd_en,
    input  logic [AW-1:0]                     i_rd_addr,
    output logic [fsfs_pkg::OFFSET_W-1:0]     o_rd_data
);

    logic [fsfs_pkg::OFFSET_W-1:0] r_mem [DEPTH];
    logic [fsfs_pkg::OFFSET_W-1:0] r_rd_data;

    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== rtl/core/fsfs_search.sv =====
// ----------------------------------------------------------------------------
// fsfs_search
// command decode and binary search sequencer around one shared add/compare
// ----------------------------------------------------------------------------
module fsfs_search #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int CW    = 13
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fsfs_pkg::t_cfg                    i_cfg,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_cmd,
    input  logic [fsfs_pkg::INDEX_W-1:0]      i_entry_index,
    input  logic [fsfs_pkg::OFFSET_W-1:0]     i_entry_offset,
    input  logic [fsfs_pkg::ADDR_W-1:0]       i_query_address,
    output logic                              o_wr_en,
    output logic [AW-1:0]                     o_wr_addr,
    output logic [fsfs_pkg::OFFSET_W-1:0]     o_wr_data,
    output logic                              o_rd_en,
    output logic [AW-1:0]                     o_rd_addr,
    input  logic [fsfs_pkg::OFFSET_W-1:0]     i_rd_data,
    output logic                              o_res_valid,
    input  logic                              i_res_ready,
    output fsfs_pkg::t_result                 o_res
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PROBE = 2'd1;
    localparam logic [1:0] ST_CMP   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]                      r_state;
    logic [CW-1:0]                   r_lo;
    logic [CW-1:0]                   r_hi;
    logic [CW-1:0]                   r_mid;
    logic [fsfs_pkg::ADDR_W-1:0]     r_addr;
    logic [fsfs_pkg::ADDR_W-1:0]     r_best;
    logic                            r_hit;

    logic                            accept;
    logic [31:0]                     idx_ext;
    logic [31:0]                     cnt_ext;
    logic [31:0]                     cnt_sat;
    logic                            eligible;
    logic [CW-1:0]                   span;
    logic [CW-1:0]                   mid;
    logic [fsfs_pkg::ADDR_W-1:0]     cand;
    logic                            cand_le;

    assign o_ready = (r_state == ST_IDLE);
    assign accept  = i_valid && o_ready;

    // table writes
    assign idx_ext   = 32'(i_entry_index);
    assign o_wr_en   = accept && (i_cmd == fsfs_pkg::CMD_LOAD) && (idx_ext < 32'(DEPTH));
    assign o_wr_addr = idx_ext[AW-1:0];
    assign o_wr_data = i_entry_offset;

    // query setup
    assign cnt_ext  = 32'(i_cfg.entry_count);
    assign cnt_sat  = (cnt_ext > 32'(DEPTH)) ? 32'(DEPTH) : cnt_ext;
    assign eligible = (i_query_address >= i_cfg.module_low)
                   && (i_query_address <  i_cfg.module_high)
                   && (i_cfg.table_base != '0)
                   && (cnt_sat != '0);

    // probe address
    assign span      = r_hi - r_lo;
    assign mid       = r_lo + (span >> 1);
    assign o_rd_en   = (r_state == ST_PROBE) && (r_lo < r_hi);
    assign o_rd_addr = mid[AW-1:0];

    // shared add and compare
    assign cand    = i_cfg.table_base
                   + {{(fsfs_pkg::ADDR_W - fsfs_pkg::OFFSET_W){i_rd_data[fsfs_pkg::OFFSET_W-1]}},
                      i_rd_data};
    assign cand_le = (cand <= r_addr);

    assign o_res_valid      = (r_state == ST_DONE);
    assign o_res.found      = r_hit;
    assign o_res.start_addr = r_hit ? r_best : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (accept && (i_cmd == fsfs_pkg::CMD_QUERY)) begin
                        r_state <= ST_PROBE;
                    end
                end
                ST_PROBE: begin
                    r_state <= (r_lo < r_hi) ? ST_CMP : ST_DONE;
                end
                ST_CMP: begin
                    r_state <= ST_PROBE;
                end
                ST_DONE: begin
                    if (i_res_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_addr <= i_query_address;
            r_lo   <= '0;
            r_hi   <= eligible ? cnt_sat[CW-1:0] : '0;
            r_best <= '0;
            r_hit  <= 1'b0;
        end else if (r_state == ST_PROBE) begin
            r_mid <= mid;
        end else if (r_state == ST_CMP) begin
            if (cand_le) begin
                r_best <= cand;
                r_hit  <= 1'b1;
                r_lo   <= r_mid + CW'(1);
            end else begin
                r_hi <= r_mid;
            end
        end
    end

endmodule

// ===== rtl/core/function_start_floor_search_top.sv =====
// ----------------------------------------------------------------------------
// function_start_floor_search_top
// floor lookup of an address in a sorted table of signed start offsets
// ----------------------------------------------------------------------------
// A load transfer (tuser 0) writes one offset into the table and gives no
// result. A query transfer (tuser 1) gives one result: the greatest
// table_base + offset not above the address, or not found. Each binary
// search probe is one table read, then one 64-bit add and compare, and a
// query makes at most 13 probes for 4096 entries. The input is not ready
// while a query is in progress. Results wait in an output register, so the
// next transfer is taken while a result is still pending. Entries read by a
// query must have been loaded beforehand.
module function_start_floor_search_top #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [fsfs_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [fsfs_pkg::ADDR_W-1:0]           i_cfg_data,
    // input stream
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [111:0]                          s_axis_tdata,  // entry_index, entry_offset, query_address, zero pad
    input  logic                                  s_axis_tuser,  // cmd
    // result stream
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [fsfs_pkg::ADDR_W-1:0]           m_axis_tdata,  // start address
    output logic                                  m_axis_tuser   // found
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    fsfs_pkg::t_cfg                  cfg;
    fsfs_pkg::t_result               res;
    fsfs_pkg::t_result               r_out;
    logic                            r_out_valid;
    logic                            res_valid;
    logic                            res_ready;
    logic                            wr_en;
    logic [AW-1:0]                   wr_addr;
    logic [fsfs_pkg::OFFSET_W-1:0]   wr_data;
    logic                            rd_en;
    logic [AW-1:0]                   rd_addr;
    logic [fsfs_pkg::OFFSET_W-1:0]   rd_data;

    fsfs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    fsfs_mem #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    fsfs_search #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_search (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_cmd           (s_axis_tuser),
        .i_entry_index   (s_axis_tdata[11:0]),
        .i_entry_offset  (s_axis_tdata[43:12]),
        .i_query_address (s_axis_tdata[107:44]),
        .o_wr_en         (wr_en),
        .o_wr_addr       (wr_addr),
        .o_wr_data       (wr_data),
        .o_rd_en         (rd_en),
        .o_rd_addr       (rd_addr),
        .i_rd_data       (rd_data),
        .o_res_valid     (res_valid),
        .i_res_ready     (res_ready),
        .o_res           (res)
    );

    // output register
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.start_addr;
    assign m_axis_tuser  = r_out.found;

endmodule
